[rtl/hierarchical_time_profiler_top_macros.svh]
// Assertion macros shared by the profiler modules.
`ifndef HIERARCHICAL_TIME_PROFILER_TOP_MACROS_SVH
`define HIERARCHICAL_TIME_PROFILER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTP_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTP_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/htp_pkg.sv]
package htp_pkg;

  // Action codes of an input beat.
  localparam logic [2:0] ACT_ENTER = 3'd0;
  localparam logic [2:0] ACT_EXIT  = 3'd1;
  localparam logic [2:0] ACT_BEGIN = 3'd2;
  localparam logic [2:0] ACT_END   = 3'd3;
  localparam logic [2:0] ACT_SWAP  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_ACCEPT  = 4'd1;
  localparam logic [3:0] CMD_ENT_RD  = 4'd2;
  localparam logic [3:0] CMD_ENT_WR  = 4'd3;
  localparam logic [3:0] CMD_EXT_STK = 4'd4;
  localparam logic [3:0] CMD_EXT_PRD = 4'd5;
  localparam logic [3:0] CMD_EXT_PWR = 4'd6;
  localparam logic [3:0] CMD_EXT_ARD = 4'd7;
  localparam logic [3:0] CMD_EXT_AWR = 4'd8;
  localparam logic [3:0] CMD_RD_RD   = 4'd9;
  localparam logic [3:0] CMD_RD_OUT  = 4'd10;
  localparam logic [3:0] CMD_SIMPLE  = 4'd11;
  localparam logic [3:0] CMD_ERROR   = 4'd12;
  localparam logic [3:0] CMD_CLR     = 4'd13;

  // Shift used for the reciprocal that reduces the anchor index.
  localparam int RECIP_SHIFT = 24;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       stk_empty;
    logic       stk_full;
    logic       clr_done;
  } stat_t;

  // One anchor record of the timing tables.
  typedef struct packed {
    logic [63:0] incl;
    logic [63:0] excl;
    logic [31:0] hits;
    logic [63:0] bytes;
  } entry_t;

  // One open-block record of the stack.
  typedef struct packed {
    logic [11:0] anchor;
    logic [11:0] parent;
    logic [63:0] start;
    logic [63:0] old_incl;
  } stk_t;

endpackage

[rtl/htp_ctrl.sv]
module htp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  htp_pkg::stat_t stat_i,
  output htp_pkg::cmd_t  cmd_o
);

  `include "hierarchical_time_profiler_top_macros.svh"

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PREP    = 4'd2;
  localparam logic [3:0] S_DISP    = 4'd3;
  localparam logic [3:0] S_ENT_RD  = 4'd4;
  localparam logic [3:0] S_ENT_WR  = 4'd5;
  localparam logic [3:0] S_EXT_STK = 4'd6;
  localparam logic [3:0] S_EXT_PRD = 4'd7;
  localparam logic [3:0] S_EXT_PWR = 4'd8;
  localparam logic [3:0] S_EXT_ARD = 4'd9;
  localparam logic [3:0] S_EXT_AWR = 4'd10;
  localparam logic [3:0] S_RD_RD   = 4'd11;
  localparam logic [3:0] S_RD_OUT  = 4'd12;

  logic [3:0] state_q, state_d;

  // Next state and command for each state.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = htp_pkg::CMD_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = htp_pkg::CMD_CLR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = htp_pkg::CMD_ACCEPT;
          state_d  = S_PREP;
        end
      end
      S_PREP: state_d = S_DISP;
      S_DISP: begin
        case (stat_i.action)
          htp_pkg::ACT_ENTER: begin
            if (stat_i.stk_full) begin
              cmd_o.op = htp_pkg::CMD_ERROR;
              state_d  = S_IDLE;
            end else begin
              state_d = S_ENT_RD;
            end
          end
          htp_pkg::ACT_EXIT: begin
            if (stat_i.stk_empty) begin
              cmd_o.op = htp_pkg::CMD_ERROR;
              state_d  = S_IDLE;
            end else begin
              state_d = S_EXT_STK;
            end
          end
          htp_pkg::ACT_READ: state_d = S_RD_RD;
          htp_pkg::ACT_SWAP: begin
            cmd_o.op = htp_pkg::CMD_SIMPLE;
            state_d  = S_CLEAR;
          end
          default: begin
            cmd_o.op = htp_pkg::CMD_SIMPLE;
            state_d  = S_IDLE;
          end
        endcase
      end
      S_ENT_RD: begin
        cmd_o.op = htp_pkg::CMD_ENT_RD;
        state_d  = S_ENT_WR;
      end
      S_ENT_WR: begin
        cmd_o.op = htp_pkg::CMD_ENT_WR;
        state_d  = S_IDLE;
      end
      S_EXT_STK: begin
        cmd_o.op = htp_pkg::CMD_EXT_STK;
        state_d  = S_EXT_PRD;
      end
      S_EXT_PRD: begin
        cmd_o.op = htp_pkg::CMD_EXT_PRD;
        state_d  = S_EXT_PWR;
      end
      S_EXT_PWR: begin
        cmd_o.op = htp_pkg::CMD_EXT_PWR;
        state_d  = S_EXT_ARD;
      end
      S_EXT_ARD: begin
        cmd_o.op = htp_pkg::CMD_EXT_ARD;
        state_d  = S_EXT_AWR;
      end
      S_EXT_AWR: begin
        cmd_o.op = htp_pkg::CMD_EXT_AWR;
        state_d  = S_IDLE;
      end
      S_RD_RD: begin
        cmd_o.op = htp_pkg::CMD_RD_RD;
        state_d  = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd_o.op = htp_pkg::CMD_RD_OUT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register; reset starts the table clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  `HTP_ASSERT_NXT(a_accept_prep, clk_i, rst_ni, start && !busy, state_q == S_PREP)
  `HTP_ASSERT_IMP(a_ent_wr_after_rd, clk_i, rst_ni, state_q == S_ENT_WR,
                  $past(state_q) == S_ENT_RD)
  `HTP_ASSERT_IMP(a_clear_from_swap, clk_i, rst_ni,
                  state_q == S_CLEAR && $past(state_q) == S_DISP,
                  $past(stat_i.action) == htp_pkg::ACT_SWAP)

endmodule

[rtl/htp_datapath.sv]
module htp_datapath #(
  parameter int ANCHOR_COUNT = 4096,
  parameter int STACK_DEPTH  = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htp_pkg::cmd_t  cmd_i,
  output htp_pkg::stat_t stat_o,
  input  logic [2:0]     action_i,
  input  logic [11:0]    anchor_index_i,
  input  logic [63:0]    byte_count_i,
  input  logic [63:0]    timestamp_i,
  output logic           result_valid_o,
  output logic [63:0]    inclusive_time_o,
  output logic [63:0]    exclusive_time_o,
  output logic [31:0]    hit_total_o,
  output logic [63:0]    bytes_total_o,
  output logic [63:0]    frame_start_o,
  output logic [63:0]    frame_end_o,
  output logic [11:0]    highest_anchor_o,
  output logic           stack_error_o
);

  `include "hierarchical_time_profiler_top_macros.svh"

  localparam int SLOTS = 2 * ANCHOR_COUNT;
  localparam int AW    = $clog2(SLOTS);
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int SIW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [24:0] RECIP = 25'((64'd1 << htp_pkg::RECIP_SHIFT) / ANCHOR_COUNT);
  localparam logic [31:0] AC32  = 32'(ANCHOR_COUNT);

  // Latched input beat.
  logic [2:0]  act_q;
  logic [11:0] anc_q;
  logic [63:0] bytes_q, ts_q;

  // Anchor index reduction: reciprocal estimate, then one correction.
  logic [36:0] qprod;
  logic [11:0] quo_q;
  logic [31:0] rem0, rem1;
  logic [11:0] idx_q;

  assign qprod = 37'(anc_q) * 37'(RECIP);
  assign rem0  = 32'(anc_q) - 32'(quo_q) * AC32;
  assign rem1  = (rem0 >= AC32) ? rem0 - AC32 : rem0;

  always_ff @(posedge clk_i) begin
    quo_q <= qprod[htp_pkg::RECIP_SHIFT +: 12];
    idx_q <= rem1[11:0];
  end

  // Per-buffer frame state.
  logic        buf_q;
  logic [11:0] parent_q [2];
  logic [11:0] max_q [2];
  logic [63:0] beg_q [2];
  logic [63:0] end_q [2];

  // Open-block stack.
  htp_pkg::stk_t stk_mem [STACK_DEPTH];
  htp_pkg::stk_t stk_rd_q, top_q;
  logic [DW-1:0] depth_q, depth_m1;
  logic [63:0]   elapsed_q;

  // Timing tables, both buffers in one memory.
  htp_pkg::entry_t mem [SLOTS];
  htp_pkg::entry_t mem_rd_q, mem_wdata;
  logic [AW-1:0]   mem_addr, clr_addr_q, clr_end_q;
  logic            mem_we, mem_re;

  function automatic logic [AW-1:0] slot(input logic b, input logic [11:0] a);
    slot = b ? AW'(ANCHOR_COUNT) + AW'(a) : AW'(a);
  endfunction

  assign depth_m1 = depth_q - 1'b1;

  // Status toward the controller.
  assign stat_o.action    = act_q;
  assign stat_o.stk_empty = (depth_q == '0);
  assign stat_o.stk_full  = (depth_q == DW'(STACK_DEPTH));
  assign stat_o.clr_done  = (clr_addr_q == clr_end_q);

  // Table port address and write data per command.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = clr_addr_q;
    mem_wdata = mem_rd_q;
    case (cmd_i.op)
      htp_pkg::CMD_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      htp_pkg::CMD_ENT_RD: begin
        mem_re   = 1'b1;
        mem_addr = slot(buf_q, idx_q);
      end
      htp_pkg::CMD_ENT_WR: begin
        mem_we          = 1'b1;
        mem_addr        = slot(buf_q, idx_q);
        mem_wdata.bytes = mem_rd_q.bytes + bytes_q;
      end
      htp_pkg::CMD_EXT_PRD: begin
        mem_re   = 1'b1;
        mem_addr = slot(buf_q, stk_rd_q.parent);
      end
      htp_pkg::CMD_EXT_PWR: begin
        mem_we         = 1'b1;
        mem_addr       = slot(buf_q, top_q.parent);
        mem_wdata.excl = mem_rd_q.excl - elapsed_q;
      end
      htp_pkg::CMD_EXT_ARD: begin
        mem_re   = 1'b1;
        mem_addr = slot(buf_q, top_q.anchor);
      end
      htp_pkg::CMD_EXT_AWR: begin
        mem_we         = 1'b1;
        mem_addr       = slot(buf_q, top_q.anchor);
        mem_wdata.excl = mem_rd_q.excl + elapsed_q;
        mem_wdata.incl = top_q.old_incl + elapsed_q;
        mem_wdata.hits = mem_rd_q.hits + 32'd1;
      end
      htp_pkg::CMD_RD_RD: begin
        mem_re   = 1'b1;
        mem_addr = slot(!buf_q, idx_q);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rd_q <= mem[mem_addr];
  end

  // Stack memory: push on enter, registered read of the top on exit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == htp_pkg::CMD_ENT_WR) begin
      stk_mem[depth_q[SIW-1:0]] <= '{anchor: idx_q, parent: parent_q[buf_q],
                                     start: ts_q, old_incl: mem_rd_q.incl};
    end
    if (cmd_i.op == htp_pkg::CMD_EXT_STK) stk_rd_q <= stk_mem[depth_m1[SIW-1:0]];
    if (cmd_i.op == htp_pkg::CMD_EXT_PRD) begin
      top_q     <= stk_rd_q;
      elapsed_q <= ts_q - stk_rd_q.start;
    end
  end

  // Input beat latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == htp_pkg::CMD_ACCEPT) begin
      act_q   <= action_i;
      anc_q   <= anchor_index_i;
      bytes_q <= byte_count_i;
      ts_q    <= timestamp_i;
    end
  end

  // Control state: stack depth, buffer select, frame registers, clear sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      buf_q      <= 1'b0;
      parent_q   <= '{default: '0};
      max_q      <= '{default: '0};
      beg_q      <= '{default: '0};
      end_q      <= '{default: '0};
      clr_addr_q <= '0;
      clr_end_q  <= AW'(SLOTS - 1);
    end else begin
      case (cmd_i.op)
        htp_pkg::CMD_CLR: begin
          if (clr_addr_q != clr_end_q) clr_addr_q <= clr_addr_q + 1'b1;
        end
        htp_pkg::CMD_ENT_WR: begin
          depth_q         <= depth_q + 1'b1;
          parent_q[buf_q] <= idx_q;
          if (idx_q > max_q[buf_q]) max_q[buf_q] <= idx_q;
        end
        htp_pkg::CMD_EXT_STK: depth_q <= depth_m1;
        htp_pkg::CMD_EXT_PRD: parent_q[buf_q] <= stk_rd_q.parent;
        htp_pkg::CMD_SIMPLE: begin
          case (act_q)
            htp_pkg::ACT_BEGIN: beg_q[buf_q] <= ts_q;
            htp_pkg::ACT_END:   end_q[buf_q] <= ts_q;
            htp_pkg::ACT_SWAP: begin
              buf_q      <= !buf_q;
              clr_addr_q <= slot(!buf_q, 12'd0);
              clr_end_q  <= slot(!buf_q, 12'd0) + AW'(ANCHOR_COUNT - 1);
            end
            default: buf_q <= buf_q;
          endcase
        end
        default: depth_q <= depth_q;
      endcase
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (cmd_i.op == htp_pkg::CMD_ENT_WR) ||
                        (cmd_i.op == htp_pkg::CMD_EXT_AWR) ||
                        (cmd_i.op == htp_pkg::CMD_RD_OUT) ||
                        (cmd_i.op == htp_pkg::CMD_SIMPLE) ||
                        (cmd_i.op == htp_pkg::CMD_ERROR);
    end
  end

  // Result payload: read fields only on a read, error flag only on an error.
  always_ff @(posedge clk_i) begin
    stack_error_o <= (cmd_i.op == htp_pkg::CMD_ERROR);
    if (cmd_i.op == htp_pkg::CMD_RD_OUT) begin
      inclusive_time_o <= mem_rd_q.incl;
      exclusive_time_o <= mem_rd_q.excl;
      hit_total_o      <= mem_rd_q.hits;
      bytes_total_o    <= mem_rd_q.bytes;
      frame_start_o    <= beg_q[!buf_q];
      frame_end_o      <= end_q[!buf_q];
      highest_anchor_o <= max_q[!buf_q];
    end else begin
      inclusive_time_o <= '0;
      exclusive_time_o <= '0;
      hit_total_o      <= '0;
      bytes_total_o    <= '0;
      frame_start_o    <= '0;
      frame_end_o      <= '0;
      highest_anchor_o <= '0;
    end
  end

  `HTP_ASSERT_IMP(a_depth_bound, clk_i, rst_ni, 1'b1, depth_q <= DW'(STACK_DEPTH))
  `HTP_ASSERT_IMP(a_push_not_full, clk_i, rst_ni, cmd_i.op == htp_pkg::CMD_ENT_WR,
                  depth_q != DW'(STACK_DEPTH))
  `HTP_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)

endmodule

[rtl/hierarchical_time_profiler_top.sv]
// Channel   Handshake                    Payload
// input     start / busy                 action_i, anchor_index_i, byte_count_i, timestamp_i
// result    result_valid_o (one cycle)   inclusive_time_o ... stack_error_o
//
// Each beat passes the prepare and dispatch states; frame begin, end, swap, unknown
// actions and stack errors register their result from dispatch, enter and read add
// a table read and then a write or output step, and exit adds a stack read and two
// read-modify-writes on the single-port table memory. After reset, busy stays high
// while the tables are cleared; a swap adds a clearing sweep of the new buffer after
// its result. The receiver cannot stall; a new beat is accepted once busy is low.
module hierarchical_time_profiler_top #(
  parameter int ANCHOR_COUNT = 4096,
  parameter int STACK_DEPTH  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [11:0] anchor_index_i,
  input  logic [63:0] byte_count_i,
  input  logic [63:0] timestamp_i,
  output logic        result_valid_o,
  output logic [63:0] inclusive_time_o,
  output logic [63:0] exclusive_time_o,
  output logic [31:0] hit_total_o,
  output logic [63:0] bytes_total_o,
  output logic [63:0] frame_start_o,
  output logic [63:0] frame_end_o,
  output logic [11:0] highest_anchor_o,
  output logic        stack_error_o
);

  htp_pkg::cmd_t  cmd;
  htp_pkg::stat_t stat;

  // Sequencer.
  htp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Tables, stack and result registers.
  htp_datapath #(
    .ANCHOR_COUNT (ANCHOR_COUNT),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .anchor_index_i   (anchor_index_i),
    .byte_count_i     (byte_count_i),
    .timestamp_i      (timestamp_i),
    .result_valid_o   (result_valid_o),
    .inclusive_time_o (inclusive_time_o),
    .exclusive_time_o (exclusive_time_o),
    .hit_total_o      (hit_total_o),
    .bytes_total_o    (bytes_total_o),
    .frame_start_o    (frame_start_o),
    .frame_end_o      (frame_end_o),
    .highest_anchor_o (highest_anchor_o),
    .stack_error_o    (stack_error_o)
  );

endmodule
